// ----- rtl/core/psfm_pkg.sv -----
// psfm_pkg: shared types and constants of the power-module fault monitor.
// Holds the per-module state record, the item and measurement structs,
// command and state enums. No dependencies.
package psfm_pkg;

    typedef enum logic [1:0] {
        CMD_STATUS = 2'd0,
        CMD_PHASE  = 2'd1,
        CMD_MEAS   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CONVERT,
        S_POWER,
        S_COMMIT
    } t_state;

    localparam logic CFG_SETPOINT_V = 1'b0;
    localparam logic CFG_SETPOINT_I = 1'b1;

    localparam logic [7:0] CODE_EMPTY      = 8'hFF;
    localparam logic [7:0] CODE_NONE       = 8'd0;
    localparam logic [7:0] CODE_SHORT      = 8'd5;
    localparam logic [7:0] CODE_PHASE_IMB  = 8'd12;
    localparam logic [7:0] CODE_PHASE_LOSS = 8'd13;
    localparam logic [7:0] CODE_PWR_LIMIT  = 8'd14;
    localparam logic [7:0] CODE_BAND_LO    = 8'd5;
    localparam logic [7:0] CODE_BAND_HI    = 8'd20;

    localparam logic [7:0]  TEMP_RESET     = 8'd20;
    localparam logic [15:0] PHASE_MIN_MAX  = 16'd1000;
    localparam logic [22:0] RATIO_LOSS     = 23'd70;
    localparam logic [22:0] RATIO_IMB      = 23'd85;
    localparam logic [22:0] RATIO_SCALE    = 23'd100;
    localparam logic [17:0] PWR_LIMIT_VA   = 18'd50000;
    localparam logic [15:0] ACTIVE_MIN_V   = 16'd20;

    localparam logic [31:0] V_SAT_MV       = 32'd65536000;
    localparam logic [31:0] I_SAT_MA       = 32'd32768000;
    localparam logic [15:0] V_SAT          = 16'd65535;
    localparam logic [14:0] I_SAT          = 15'd32767;
    localparam logic [26:0] RECIP_1000     = 27'd68719476;
    localparam logic [25:0] MILLI_PER_UNIT = 26'd1000;

    typedef struct packed {
        logic [2:0][7:0] hist;
        logic [7:0]      st1;
        logic [7:0]      st2;
        logic [7:0]      temp;
        logic [15:0]     volt;
        logic [14:0]     curr;
        logic [30:0]     power;
        logic            active;
        logic            fault;
        logic            short_ckt;
    } t_rec;

    typedef struct packed {
        t_cmd        cmd;
        logic        on;
        logic        pl_ok;
        logic [63:0] payload;
    } t_item;

    typedef struct packed {
        logic [15:0] volt;
        logic [14:0] curr;
        logic [30:0] power;
    } t_meas;

    localparam t_rec REC_RESET = '{
        hist: {CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
        st1: 8'd0, st2: 8'd0, temp: TEMP_RESET,
        volt: 16'd0, curr: 15'd0, power: 31'd0,
        active: 1'b0, fault: 1'b0, short_ckt: 1'b0
    };

    localparam t_rec REC_EMPTY = '{
        hist: {CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
        st1: 8'd0, st2: 8'd0, temp: 8'd0,
        volt: 16'd0, curr: 15'd0, power: 31'd0,
        active: 1'b0, fault: 1'b0, short_ckt: 1'b0
    };

endpackage

// ----- rtl/core/psu_fault_monitor.sv -----
// psu_fault_monitor: top level of the power-module fault monitor.
// Depends on psfm_pkg, psfm_ram, psfm_conv and psfm_update.
//
// Input channel (i_in_valid / o_in_ready) carries one item per beat: a
// command, a module address, the commanded-on flag and a 64-bit frame.
// Output channel (o_out_valid / i_out_ready) carries one result per item:
// the addressed module's record after the update and a changed bit (out of range: empty).
// Configuration: i_cfg_we writes setpoint voltage (index 0) or setpoint
// current (index 1) from i_cfg_data in the same cycle.
// The result is registered in the output register at write-back. An item
// passes through accept, state-memory read with divide-by-1000 estimate,
// correction, power product, then write-back of the module record.
// Items are taken one at a time; the state memory is read once and written
// at most once per item, so no forwarding is needed.
// Reset clears the per-entry valid bits, so every module reads as its
// reset record until first written; no clearing pass runs. The output
// register empties.
// A stalled result holds in the output register; the next item is still
// accepted and processed, and its write-back waits until the output frees.
module psu_fault_monitor #(
    parameter int MODULES = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_command,
    input  logic [3:0]        i_module_addr,
    input  logic              i_commanded_on,
    input  logic [63:0]       i_payload,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_code_newest,
    output logic [7:0]        o_code_middle,
    output logic [7:0]        o_code_oldest,
    output logic              o_fault_latched,
    output logic              o_short_latched,
    output logic              o_changed,
    output logic signed [7:0] o_module_temperature,
    output logic [15:0]       o_output_voltage,
    output logic [14:0]       o_output_current,
    output logic [30:0]       o_output_power,
    output logic              o_output_active,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [9:0]        i_cfg_data
);

    localparam int AW = MODULES > 1 ? $clog2(MODULES) : 1;
    localparam logic [4:0] MOD_COUNT = 5'(MODULES);
    localparam int REC_W = $bits(psfm_pkg::t_rec);

    psfm_pkg::t_state r_state;
    psfm_pkg::t_state n_state;

    logic [9:0]         r_sv;
    logic [7:0]         r_sc;
    logic               r_pl_ok;
    psfm_pkg::t_cmd     r_cmd;
    logic [3:0]         r_addr;
    logic               r_on;
    logic [63:0]        r_payload;
    logic [MODULES-1:0] r_valid;
    psfm_pkg::t_rec     r_out;
    logic               r_out_changed;
    logic               r_out_valid;

    logic               accept;
    logic               commit;
    logic               in_range;
    logic [REC_W-1:0]   rdata;
    psfm_pkg::t_rec     old_rec;
    psfm_pkg::t_rec     new_rec;
    psfm_pkg::t_item    item;
    psfm_pkg::t_meas    meas;
    logic               changed;

    assign o_in_ready = (r_state == psfm_pkg::S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = {1'b0, r_addr} < MOD_COUNT;

    always_comb begin
        n_state = r_state;
        commit  = 1'b0;
        unique case (r_state)
            psfm_pkg::S_IDLE: begin
                if (accept) n_state = psfm_pkg::S_LOOKUP;
            end
            psfm_pkg::S_LOOKUP:  n_state = psfm_pkg::S_CONVERT;
            psfm_pkg::S_CONVERT: n_state = psfm_pkg::S_POWER;
            psfm_pkg::S_POWER:   n_state = psfm_pkg::S_COMMIT;
            psfm_pkg::S_COMMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    commit  = 1'b1;
                    n_state = psfm_pkg::S_IDLE;
                end
            end
            default: n_state = psfm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psfm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv    <= 10'd0;
            r_sc    <= 8'd0;
            r_pl_ok <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    psfm_pkg::CFG_SETPOINT_V: r_sv <= i_cfg_data;
                    psfm_pkg::CFG_SETPOINT_I: r_sc <= i_cfg_data[7:0];
                    default: r_sv <= r_sv;
                endcase
            end
            r_pl_ok <= (18'(r_sv) * 18'(r_sc)) > psfm_pkg::PWR_LIMIT_VA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= psfm_pkg::t_cmd'(i_command);
            r_addr    <= i_module_addr;
            r_on      <= i_commanded_on;
            r_payload <= i_payload;
        end
    end

    psfm_ram #(
        .WIDTH (REC_W),
        .DEPTH (MODULES)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (commit && in_range),
        .i_waddr (r_addr[AW-1:0]),
        .i_wdata (new_rec),
        .i_re    (accept),
        .i_raddr (i_module_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    psfm_conv u_conv (
        .i_clk  (i_clk),
        .i_vmv  (r_payload[63:32]),
        .i_ima  (r_payload[31:0]),
        .o_meas (meas)
    );

    assign old_rec = (in_range && r_valid[r_addr[AW-1:0]]) ? psfm_pkg::t_rec'(rdata)
                                                           : psfm_pkg::REC_RESET;
    assign item = '{cmd: r_cmd, on: r_on, pl_ok: r_pl_ok, payload: r_payload};

    psfm_update u_update (
        .i_old     (old_rec),
        .i_item    (item),
        .i_meas    (meas),
        .o_new     (new_rec),
        .o_changed (changed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (commit && in_range) begin
            r_valid[r_addr[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out         <= in_range ? new_rec : psfm_pkg::REC_EMPTY;
            r_out_changed <= in_range && changed;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_code_newest        = r_out.hist[0];
    assign o_code_middle        = r_out.hist[1];
    assign o_code_oldest        = r_out.hist[2];
    assign o_fault_latched      = r_out.fault;
    assign o_short_latched      = r_out.short_ckt;
    assign o_changed            = r_out_changed;
    assign o_module_temperature = r_out.temp;
    assign o_output_voltage     = r_out.volt;
    assign o_output_current     = r_out.curr;
    assign o_output_power       = r_out.power;
    assign o_output_active      = r_out.active;

endmodule

// ----- rtl/core/psfm_ram.sv -----
// psfm_ram: generic single-write, single-read RAM with registered read.
// Parameters set word width and depth. No dependencies.
module psfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/core/psfm_conv.sv -----
// psfm_conv: three-stage mV/mA to V/A conversion with saturation and power.
// Divides by 1000 through a reciprocal product and one correction step.
// Depends on psfm_pkg.
module psfm_conv (
    input  logic             i_clk,
    input  logic [31:0]      i_vmv,
    input  logic [31:0]      i_ima,
    output psfm_pkg::t_meas  o_meas
);

    logic        r_vsat;
    logic        r_isat;
    logic [25:0] r_vx;
    logic [25:0] r_ix;
    logic [15:0] r_vq;
    logic [14:0] r_iq;
    logic [15:0] r_volt;
    logic [14:0] r_curr;
    logic [30:0] r_power;

    logic [52:0] vprod;
    logic [52:0] iprod;
    logic [25:0] vrem;
    logic [25:0] irem;
    logic [15:0] n_volt;
    logic [14:0] n_curr;

    always_comb begin
        vprod = 53'(i_vmv[25:0]) * 53'(psfm_pkg::RECIP_1000);
        iprod = 53'(i_ima[24:0]) * 53'(psfm_pkg::RECIP_1000);
        vrem  = r_vx - 26'(26'(r_vq) * psfm_pkg::MILLI_PER_UNIT);
        irem  = r_ix - 26'(26'(r_iq) * psfm_pkg::MILLI_PER_UNIT);
        if (r_vsat) begin
            n_volt = psfm_pkg::V_SAT;
        end else if (vrem >= psfm_pkg::MILLI_PER_UNIT) begin
            n_volt = r_vq + 16'd1;
        end else begin
            n_volt = r_vq;
        end
        if (r_isat) begin
            n_curr = psfm_pkg::I_SAT;
        end else if (irem >= psfm_pkg::MILLI_PER_UNIT) begin
            n_curr = r_iq + 15'd1;
        end else begin
            n_curr = r_iq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vsat  <= i_vmv >= psfm_pkg::V_SAT_MV;
        r_isat  <= i_ima >= psfm_pkg::I_SAT_MA;
        r_vx    <= i_vmv[25:0];
        r_ix    <= {1'b0, i_ima[24:0]};
        r_vq    <= vprod[51:36];
        r_iq    <= iprod[50:36];
        r_volt  <= n_volt;
        r_curr  <= n_curr;
        r_power <= 31'(31'(r_volt) * 31'(r_curr));
    end

    assign o_meas = '{volt: r_volt, curr: r_curr, power: r_power};

endmodule

// ----- rtl/core/psfm_update.sv -----
// psfm_update: next-state logic of one module record for one item.
// Status decode, history push, latches, phase check, measurement store.
// Depends on psfm_pkg.
module psfm_update (
    input  psfm_pkg::t_rec  i_old,
    input  psfm_pkg::t_item i_item,
    input  psfm_pkg::t_meas i_meas,
    output psfm_pkg::t_rec  o_new,
    output logic            o_changed
);

    function automatic logic [7:0] st_decode(input logic [7:0] st1, input logic [7:0] st2);
        logic [7:0] code;
        code = psfm_pkg::CODE_NONE;
        if      (st2[7]) code = 8'd9;
        else if (st2[6]) code = 8'd10;
        else if (st2[5]) code = 8'd11;
        else if (st2[4]) code = 8'd12;
        else if (st2[3]) code = 8'd13;
        else if (st2[2]) code = 8'd5;
        else if (st2[0]) code = 8'd14;
        else if (st1[7]) code = 8'd8;
        else if (st1[6]) code = 8'd15;
        else if (st1[5]) code = 8'd16;
        else if (st1[4]) code = 8'd6;
        else if (st1[3]) code = 8'd7;
        else if (st1[2]) code = 8'd17;
        else if (st1[1]) code = 8'd18;
        else if (st1[0]) code = 8'd19;
        return code;
    endfunction

    function automatic logic in_band(input logic [7:0] c);
        return (c >= psfm_pkg::CODE_BAND_LO) && (c <= psfm_pkg::CODE_BAND_HI);
    endfunction

    function automatic logic [2:0][7:0] push(input logic [2:0][7:0] h, input logic [7:0] c);
        logic [2:0][7:0] r;
        r = h;
        if (h[0] != c) begin
            r = {h[1], h[0], c};
        end
        return r;
    endfunction

    logic [7:0]  temp;
    logic [7:0]  st1;
    logic [7:0]  st2;
    logic [7:0]  fault;
    logic [7:0]  second;
    logic [7:0]  fc;
    logic [7:0]  pf;
    logic [15:0] pa;
    logic [15:0] pb;
    logic [15:0] pc;
    logic [15:0] mx;
    logic [15:0] mn;
    logic [22:0] mn100;
    logic        act;

    always_comb begin
        o_new     = i_old;
        o_changed = 1'b0;
        temp   = i_item.payload[31:24];
        st2    = i_item.payload[15:8];
        st1    = i_item.payload[7:0];
        fault  = st_decode(st1, st2);
        second = st_decode(st1, st2 & 8'hFE);
        pa     = i_item.payload[63:48];
        pb     = i_item.payload[47:32];
        pc     = i_item.payload[31:16];
        mx     = pa;
        mn     = pa;
        if (pb > mx) mx = pb;
        if (pc > mx) mx = pc;
        if (pb < mn) mn = pb;
        if (pc < mn) mn = pc;
        mn100 = 23'(mn) * psfm_pkg::RATIO_SCALE;
        if (mn100 < 23'(mx) * psfm_pkg::RATIO_LOSS) begin
            pf = psfm_pkg::CODE_PHASE_LOSS;
        end else if (mn100 < 23'(mx) * psfm_pkg::RATIO_IMB) begin
            pf = psfm_pkg::CODE_PHASE_IMB;
        end else begin
            pf = psfm_pkg::CODE_NONE;
        end
        fc  = (fault == psfm_pkg::CODE_PWR_LIMIT && in_band(second)) ? second : fault;
        act = i_meas.volt >= psfm_pkg::ACTIVE_MIN_V;

        case (i_item.cmd)
            psfm_pkg::CMD_STATUS: begin
                o_new.temp = temp;
                if (temp != i_old.temp) o_changed = 1'b1;
                if (st1 != i_old.st1 || st2 != i_old.st2) begin
                    o_new.st1 = st1;
                    o_new.st2 = st2;
                    o_changed = 1'b1;
                    if (in_band(fault) &&
                        (fault != psfm_pkg::CODE_PWR_LIMIT || i_item.pl_ok)) begin
                        o_new.hist = push(o_new.hist, fault);
                    end
                    if (fault == psfm_pkg::CODE_PWR_LIMIT && in_band(second) &&
                        second != psfm_pkg::CODE_PWR_LIMIT && i_item.on) begin
                        o_new.hist = push(o_new.hist, second);
                    end
                    if (i_item.on) begin
                        if (in_band(fc) && fc != psfm_pkg::CODE_PWR_LIMIT) o_new.fault = 1'b1;
                        if (fc == psfm_pkg::CODE_SHORT) o_new.short_ckt = 1'b1;
                    end
                end
            end
            psfm_pkg::CMD_PHASE: begin
                if (mx >= psfm_pkg::PHASE_MIN_MAX && pf != psfm_pkg::CODE_NONE &&
                    i_item.on && i_old.hist[0] != pf) begin
                    o_new.hist = push(i_old.hist, pf);
                    o_changed  = 1'b1;
                end
            end
            psfm_pkg::CMD_MEAS: begin
                o_new.volt   = i_meas.volt;
                o_new.curr   = i_meas.curr;
                o_new.power  = i_meas.power;
                o_new.active = act;
                o_changed = (i_meas.volt != i_old.volt) || (i_meas.curr != i_old.curr) ||
                            (i_meas.power != i_old.power) || (act != i_old.active);
            end
            psfm_pkg::CMD_CLEAR: begin
                o_new.fault = 1'b0;
                o_changed   = i_old.fault;
            end
            default: begin
                o_new = i_old;
            end
        endcase
    end

endmodule

// ----- rtl/core/psfm_checker.sv -----
// psfm_checker: port-level assertions for psu_fault_monitor, bound to the top.
// Depends on psu_fault_monitor ports only.
module psfm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [7:0]        o_code_newest,
    input logic [7:0]        o_code_middle,
    input logic [7:0]        o_code_oldest,
    input logic [15:0]       o_output_voltage,
    input logic [14:0]       o_output_current,
    input logic [30:0]       o_output_power,
    input logic              o_output_active,
    input logic              o_fault_latched,
    input logic              o_short_latched
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_code_newest) &&
        $stable(o_output_power) && $stable(o_output_voltage))
        else $error("output beat changed while stalled");

    a_hist_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_code_newest == 8'hFF |->
        o_code_middle == 8'hFF && o_code_oldest == 8'hFF)
        else $error("history not filled newest first");

    a_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_output_active == (o_output_voltage >= 16'd20))
        else $error("active flag disagrees with voltage");

    a_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_output_power != 31'd0 |->
        o_output_voltage != 16'd0 && o_output_current != 15'd0)
        else $error("power without voltage and current");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_short_latched && o_code_newest == 8'hFF |-> 1'b0)
        else $error("short latch set with empty history");

endmodule

bind psu_fault_monitor psfm_checker u_psfm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_code_newest    (o_code_newest),
    .o_code_middle    (o_code_middle),
    .o_code_oldest    (o_code_oldest),
    .o_output_voltage (o_output_voltage),
    .o_output_current (o_output_current),
    .o_output_power   (o_output_power),
    .o_output_active  (o_output_active),
    .o_fault_latched  (o_fault_latched),
    .o_short_latched  (o_short_latched)
);
